>>> design/rlpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_pkg: shared types and constants of the RGB LED pulse encoder
// Register indexes, reset values, hue arithmetic constants, and the structs
// passed between the front end, the item queue and the pulse serializer.
// ----------------------------------------------------------------------------
package rlpe_pkg;

  // Field widths
  localparam int unsigned TicksW    = 10;
  localparam int unsigned CountW    = 8;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned HueW      = 16;
  localparam int unsigned ColorW    = 3 * ChanW;
  localparam int unsigned CfgDataW  = TicksW;
  localparam int unsigned CfgIdxW   = 2;

  // Bit slots per LED and the slot counter width (one extra slot for latch)
  localparam int unsigned BitsPerLed = 24;
  localparam int unsigned SlotW      = $clog2(BitsPerLed + 1);

  // Hue reduction: quotient by 360 through a reciprocal, exact for 16 bits
  localparam int unsigned HueCircle     = 360;
  localparam int unsigned HueSegment    = 60;
  localparam int unsigned HueRecipShift = 24;
  localparam int unsigned HueRecip      = (1 << HueRecipShift) / HueCircle + 1;
  localparam int unsigned HueProdW      = 2 * HueW;
  localparam int unsigned HueQuotW      = HueProdW - HueRecipShift;
  localparam int unsigned HueModW       = 9;
  localparam int unsigned HueFracW      = 6;
  localparam int unsigned FullScale     = 255;

  // Register reset values
  localparam logic [TicksW-1:0] OneHighReset  = TicksW'(150);
  localparam logic [TicksW-1:0] ZeroHighReset = TicksW'(75);
  localparam logic [CountW-1:0] LatchReset    = CountW'(50);
  localparam logic [CountW-1:0] LedCountReset = CountW'(5);

  // Default depth of the queue between front end and serializer
  localparam int unsigned QueueDepthDefault = 2;

  // Input command codes
  typedef enum logic {
    CmdRgb = 1'b0,
    CmdHue = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgOneHigh  = 2'd0,
    CfgZeroHigh = 2'd1,
    CfgLatch    = 2'd2,
    CfgLedCount = 2'd3
  } cfg_idx_e;

  // Configuration register file
  typedef struct packed {
    logic [TicksW-1:0] one_high;
    logic [TicksW-1:0] zero_high;
    logic [CountW-1:0] latch_slots;
    logic [CountW-1:0] led_count;
  } cfg_t;

  // One classified LED request in the queue
  typedef struct packed {
    logic [ColorW-1:0] color;       // green, red, blue
    logic              frame_done;  // this LED closes the frame
  } item_t;

endpackage

>>> design/rlpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_front: request intake and colour classification
// Accepts LED requests, tracks the position in the frame, reduces a hue to a
// saturated colour and pushes packed GRB items into the queue.
// ----------------------------------------------------------------------------
module rlpe_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic                           cmd_i,
  input  logic [rlpe_pkg::ChanW-1:0]     red_i,
  input  logic [rlpe_pkg::ChanW-1:0]     green_i,
  input  logic [rlpe_pkg::ChanW-1:0]     blue_i,
  input  logic [rlpe_pkg::HueW-1:0]      hue_i,
  input  logic [rlpe_pkg::CountW-1:0]    led_count_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output rlpe_pkg::item_t                q_item_o
);

  localparam int unsigned ModCalcW = rlpe_pkg::HueQuotW + rlpe_pkg::HueModW;

  logic                               accept;
  logic                               advance;
  logic [rlpe_pkg::HueProdW-1:0]      hue_prod;
  logic [rlpe_pkg::CountW-1:0]        pos_inc;
  logic                               done_now;

  logic [rlpe_pkg::CountW-1:0]        pos_q, pos_d;
  logic                               valid_q, valid_d;
  logic                               cmd_q;
  logic [rlpe_pkg::ColorW-1:0]        rgb_q;
  logic [rlpe_pkg::HueW-1:0]          hue_q;
  logic [rlpe_pkg::HueQuotW-1:0]      quot_q;
  logic                               done_q;

  logic [ModCalcW-1:0]                mod_full;
  logic [rlpe_pkg::HueModW-1:0]       hue_mod;
  logic [2:0]                         seg;
  logic [rlpe_pkg::HueFracW-1:0]      frac;
  logic [rlpe_pkg::HueFracW-1:0]      frac_inv;
  logic [rlpe_pkg::TicksW-1:0]        rise_prod;
  logic [rlpe_pkg::TicksW-1:0]        fall_prod;
  logic [rlpe_pkg::ChanW-1:0]         rise;
  logic [rlpe_pkg::ChanW-1:0]         fall;
  logic [rlpe_pkg::ChanW-1:0]         hr, hg, hb;

  // Stage register advances when empty or when the queue takes its item
  assign advance  = !valid_q || !q_full_i;
  assign full     = !advance;
  assign accept   = push && advance;
  assign q_push_o = valid_q && !q_full_i;

  // Quotient of the hue by 360 via reciprocal multiply
  assign hue_prod = rlpe_pkg::HueProdW'(hue_i) *
                    rlpe_pkg::HueProdW'(rlpe_pkg::HueRecip);

  // Frame position: the LED that reaches the count closes the frame
  assign pos_inc  = pos_q + rlpe_pkg::CountW'(1);
  assign done_now = (pos_inc >= led_count_i);

  always_comb begin
    pos_d   = pos_q;
    valid_d = valid_q;
    if (advance) begin
      valid_d = push;
    end
    if (accept) begin
      pos_d = done_now ? '0 : pos_inc;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      rgb_q  <= {green_i, red_i, blue_i};
      hue_q  <= hue_i;
      quot_q <= hue_prod[rlpe_pkg::HueProdW-1:rlpe_pkg::HueRecipShift];
      done_q <= done_now;
    end
  end

  // Remainder modulo 360, then segment and offset within it
  assign mod_full = ModCalcW'(hue_q) -
                    ModCalcW'(quot_q) * ModCalcW'(rlpe_pkg::HueCircle);
  assign hue_mod  = mod_full[rlpe_pkg::HueModW-1:0];

  always_comb begin
    priority if (hue_mod >= rlpe_pkg::HueModW'(300)) begin
      seg  = 3'd5;
      frac = rlpe_pkg::HueFracW'(hue_mod - rlpe_pkg::HueModW'(300));
    end else if (hue_mod >= rlpe_pkg::HueModW'(240)) begin
      seg  = 3'd4;
      frac = rlpe_pkg::HueFracW'(hue_mod - rlpe_pkg::HueModW'(240));
    end else if (hue_mod >= rlpe_pkg::HueModW'(180)) begin
      seg  = 3'd3;
      frac = rlpe_pkg::HueFracW'(hue_mod - rlpe_pkg::HueModW'(180));
    end else if (hue_mod >= rlpe_pkg::HueModW'(120)) begin
      seg  = 3'd2;
      frac = rlpe_pkg::HueFracW'(hue_mod - rlpe_pkg::HueModW'(120));
    end else if (hue_mod >= rlpe_pkg::HueModW'(60)) begin
      seg  = 3'd1;
      frac = rlpe_pkg::HueFracW'(hue_mod - rlpe_pkg::HueModW'(60));
    end else begin
      seg  = 3'd0;
      frac = rlpe_pkg::HueFracW'(hue_mod);
    end
  end

  // Ramps: 255*f/60 equals 17*f/4 truncated
  assign frac_inv  = rlpe_pkg::HueFracW'(rlpe_pkg::HueSegment) - frac;
  assign rise_prod = rlpe_pkg::TicksW'(frac) * rlpe_pkg::TicksW'(17);
  assign fall_prod = rlpe_pkg::TicksW'(frac_inv) * rlpe_pkg::TicksW'(17);
  assign rise      = rise_prod[rlpe_pkg::TicksW-1:2];
  assign fall      = fall_prod[rlpe_pkg::TicksW-1:2];

  always_comb begin
    unique case (seg)
      3'd0:    begin hr = 8'(rlpe_pkg::FullScale); hg = rise; hb = '0; end
      3'd1:    begin hr = fall; hg = 8'(rlpe_pkg::FullScale); hb = '0; end
      3'd2:    begin hr = '0; hg = 8'(rlpe_pkg::FullScale); hb = rise; end
      3'd3:    begin hr = '0; hg = fall; hb = 8'(rlpe_pkg::FullScale); end
      3'd4:    begin hr = rise; hg = '0; hb = 8'(rlpe_pkg::FullScale); end
      default: begin hr = 8'(rlpe_pkg::FullScale); hg = '0; hb = fall; end
    endcase
  end

  // Pack the queue item
  always_comb begin
    q_item_o.frame_done = done_q;
    if (cmd_q == rlpe_pkg::CmdHue) begin
      q_item_o.color = {hg, hr, hb};
    end else begin
      q_item_o.color = rgb_q;
    end
  end

endmodule

>>> design/rlpe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_queue: short item queue between front end and serializer
// Register-based first-in first-out buffer of classified LED items.
// ----------------------------------------------------------------------------
module rlpe_queue #(
  parameter int unsigned Depth = rlpe_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rlpe_pkg::item_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output rlpe_pkg::item_t rdata_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rlpe_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Fill level never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill level beyond depth");

endmodule

>>> design/rlpe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_back: pulse serializer
// Expands each queued LED item into 24 bit-slot results, MSB first, plus the
// frame latch when the item closes the frame, through an output register.
// ----------------------------------------------------------------------------
module rlpe_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rlpe_pkg::cfg_t                cfg_i,
  input  logic                          q_empty_i,
  input  rlpe_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  input  logic                          pop,
  output logic                          empty,
  output logic [rlpe_pkg::TicksW-1:0]   pulse_high_o,
  output logic [rlpe_pkg::CountW-1:0]   repeat_slots_o,
  output logic                          is_latch_o,
  output logic                          run_end_o
);

  localparam logic [rlpe_pkg::SlotW-1:0] LastBit  = rlpe_pkg::SlotW'(rlpe_pkg::BitsPerLed - 1);
  localparam logic [rlpe_pkg::SlotW-1:0] LatchIdx = rlpe_pkg::SlotW'(rlpe_pkg::BitsPerLed);

  logic                              busy_q, busy_d;
  logic [rlpe_pkg::SlotW-1:0]        idx_q, idx_d;
  logic [rlpe_pkg::ColorW-1:0]       color_q, color_d;
  logic                              done_q, done_d;
  logic                              out_valid_q, out_valid_d;
  logic [rlpe_pkg::TicksW-1:0]       out_pulse_q;
  logic [rlpe_pkg::CountW-1:0]       out_rep_q;
  logic                              out_latch_q;
  logic                              out_end_q;

  logic                              out_adv;
  logic                              emit;
  logic                              last_emit;
  logic                              load;
  logic                              latch_slot;
  logic [rlpe_pkg::TicksW-1:0]       slot_pulse;
  logic [rlpe_pkg::CountW-1:0]       slot_rep;
  logic                              slot_end;

  // Output register frees up when empty or when its result is taken
  assign out_adv   = !out_valid_q || pop;
  assign emit      = busy_q && out_adv;
  assign latch_slot = (idx_q == LatchIdx);
  assign last_emit = latch_slot || ((idx_q == LastBit) && !done_q);
  assign load      = !q_empty_i && (!busy_q || (emit && last_emit));
  assign q_pop_o   = load;

  // Current slot value
  always_comb begin
    if (latch_slot) begin
      slot_pulse = '0;
      slot_rep   = (cfg_i.latch_slots == '0) ? rlpe_pkg::CountW'(1) : cfg_i.latch_slots;
    end else begin
      slot_pulse = color_q[rlpe_pkg::ColorW-1] ? cfg_i.one_high : cfg_i.zero_high;
      slot_rep   = rlpe_pkg::CountW'(1);
    end
    slot_end = last_emit;
  end

  // Advance through the slots of the current item, fetch the next one
  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    color_d     = color_q;
    done_d      = done_q;
    out_valid_d = out_adv ? busy_q : out_valid_q;
    if (emit) begin
      idx_d   = idx_q + rlpe_pkg::SlotW'(1);
      color_d = {color_q[rlpe_pkg::ColorW-2:0], 1'b0};
      if (last_emit) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      color_d = q_item_i.color;
      done_d  = q_item_i.frame_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold item payload and the result register
  always_ff @(posedge clk_i) begin
    color_q <= color_d;
    done_q  <= done_d;
    if (emit) begin
      out_pulse_q <= slot_pulse;
      out_rep_q   <= slot_rep;
      out_latch_q <= latch_slot;
      out_end_q   <= slot_end;
    end
  end

  assign empty          = !out_valid_q;
  assign pulse_high_o   = out_pulse_q;
  assign repeat_slots_o = out_rep_q;
  assign is_latch_o     = out_latch_q;
  assign run_end_o      = out_end_q;

  // The latch slot is reached only by an item that closes the frame
  a_latch_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && latch_slot |-> done_q)
    else $error("latch slot on an item that does not close the frame");

  // A latch result always ends its run and carries zero duty
  a_latch_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_latch_q |-> out_end_q && (out_pulse_q == '0))
    else $error("malformed latch result");

  // A new item is taken only when the current one is finishing or none is held
  a_load_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && busy_q |-> emit && last_emit)
    else $error("item fetched while the current one is unfinished");

  // Slot index stays within data bits plus latch
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= LatchIdx)
    else $error("slot index out of range");

endmodule

>>> design/rgb_led_pulse_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder_top: RGB LED bit-slot pulse encoder
// Path: front-end stage register, item queue, serializer, output register.
// Throughput: one result per cycle while pop is held: 24 results per LED, 25 for
//   the LED that closes a frame; the single serializer emits one slot a cycle.
// Reset: registers return to 150 / 75 / 50 / 5, frame position to 0, queue
//   and output register empty.
// ----------------------------------------------------------------------------
module rgb_led_pulse_encoder_top #(
  parameter int unsigned QueueDepth = rlpe_pkg::QueueDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [rlpe_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rlpe_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // request side
  input  logic                            push,
  output logic                            full,
  input  logic                            cmd_i,
  input  logic [rlpe_pkg::ChanW-1:0]      red_i,
  input  logic [rlpe_pkg::ChanW-1:0]      green_i,
  input  logic [rlpe_pkg::ChanW-1:0]      blue_i,
  input  logic [rlpe_pkg::HueW-1:0]       hue_i,
  // result side
  output logic                            empty,
  input  logic                            pop,
  output logic [rlpe_pkg::TicksW-1:0]     pulse_high_o,
  output logic [rlpe_pkg::CountW-1:0]     repeat_slots_o,
  output logic                            is_latch_o,
  output logic                            run_end_o
);

  rlpe_pkg::cfg_t  cfg_q, cfg_d;
  logic            q_push, q_full, q_pop, q_empty;
  rlpe_pkg::item_t q_wdata, q_rdata;

  // Decode register writes, masked to the register width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (rlpe_pkg::cfg_idx_e'(cfg_idx_i))
        rlpe_pkg::CfgOneHigh:  cfg_d.one_high    = cfg_wdata_i;
        rlpe_pkg::CfgZeroHigh: cfg_d.zero_high   = cfg_wdata_i;
        rlpe_pkg::CfgLatch:    cfg_d.latch_slots = cfg_wdata_i[rlpe_pkg::CountW-1:0];
        rlpe_pkg::CfgLedCount: cfg_d.led_count   = cfg_wdata_i[rlpe_pkg::CountW-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_high    <= rlpe_pkg::OneHighReset;
      cfg_q.zero_high   <= rlpe_pkg::ZeroHighReset;
      cfg_q.latch_slots <= rlpe_pkg::LatchReset;
      cfg_q.led_count   <= rlpe_pkg::LedCountReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rlpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .hue_i       (hue_i),
    .led_count_i (cfg_q.led_count),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_wdata)
  );

  rlpe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  rlpe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_empty_i      (q_empty),
    .q_item_i       (q_rdata),
    .q_pop_o        (q_pop),
    .pop            (pop),
    .empty          (empty),
    .pulse_high_o   (pulse_high_o),
    .repeat_slots_o (repeat_slots_o),
    .is_latch_o     (is_latch_o),
    .run_end_o      (run_end_o)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RGB LED pulse encoder
// Feeds LED colour requests (RGB and hue) through the push/full side, predicts
// the 24 bit slots and the frame latch of each LED from its own copy of the
// registers and the frame position, and checks every popped slot in order.
// Register settings change between drained phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    rlpe_pkg::cmd_e                 cmd;
    logic [rlpe_pkg::ChanW-1:0]     red;
    logic [rlpe_pkg::ChanW-1:0]     green;
    logic [rlpe_pkg::ChanW-1:0]     blue;
    logic [rlpe_pkg::HueW-1:0]      hue;
  } led_req_t;

  typedef struct {
    logic [rlpe_pkg::TicksW-1:0]    pulse_high;
    logic [rlpe_pkg::CountW-1:0]    repeat_slots;
    logic                           is_latch;
    logic                           run_end;
  } slot_t;

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             cfg_we_i    = 1'b0;
  logic [rlpe_pkg::CfgIdxW-1:0]     cfg_idx_i   = '0;
  logic [rlpe_pkg::CfgDataW-1:0]    cfg_wdata_i = '0;
  logic                             push        = 1'b0;
  logic                             full;
  logic                             cmd_i       = 1'b0;
  logic [rlpe_pkg::ChanW-1:0]       red_i       = '0;
  logic [rlpe_pkg::ChanW-1:0]       green_i     = '0;
  logic [rlpe_pkg::ChanW-1:0]       blue_i      = '0;
  logic [rlpe_pkg::HueW-1:0]        hue_i       = '0;
  logic                             empty;
  logic                             pop         = 1'b0;
  logic [rlpe_pkg::TicksW-1:0]      pulse_high_o;
  logic [rlpe_pkg::CountW-1:0]      repeat_slots_o;
  logic                             is_latch_o;
  logic                             run_end_o;

  // predictor copy of the registers and the frame position
  logic [rlpe_pkg::TicksW-1:0] one_ticks  = rlpe_pkg::OneHighReset;
  logic [rlpe_pkg::TicksW-1:0] zero_ticks = rlpe_pkg::ZeroHighReset;
  logic [rlpe_pkg::CountW-1:0] latch_len  = rlpe_pkg::LatchReset;
  logic [rlpe_pkg::CountW-1:0] frame_leds = rlpe_pkg::LedCountReset;
  logic [rlpe_pkg::CountW-1:0] frame_pos  = '0;

  led_req_t    led_backlog[$];
  slot_t       due_slots[$];
  led_req_t    on_bus;
  int unsigned bad_slots = 0;
  int unsigned cyc       = 0;
  int unsigned sent      = 0;
  logic        quiet;

  rgb_led_pulse_encoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .cmd_i          (cmd_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .hue_i          (hue_i),
    .empty          (empty),
    .pop            (pop),
    .pulse_high_o   (pulse_high_o),
    .repeat_slots_o (repeat_slots_o),
    .is_latch_o     (is_latch_o),
    .run_end_o      (run_end_o)
  );

  // Clock: 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Count cycles; hold both sides free of idling inside one window
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end
  assign quiet = (cyc >= 1500) && (cyc < 4500);

  // Expand one LED request into its bit slots and the latch that closes a frame
  function automatic void encode_led(led_req_t req);
    int unsigned                    h;
    int unsigned                    seg;
    int unsigned                    f;
    int unsigned                    t;
    int unsigned                    q;
    logic [rlpe_pkg::ChanW-1:0]     r;
    logic [rlpe_pkg::ChanW-1:0]     g;
    logic [rlpe_pkg::ChanW-1:0]     b;
    logic [rlpe_pkg::ColorW-1:0]    grb;
    logic                           closes;
    slot_t                          s;
    if (req.cmd == rlpe_pkg::CmdHue) begin
      h   = 32'(req.hue) % rlpe_pkg::HueCircle;
      seg = h / rlpe_pkg::HueSegment;
      f   = h % rlpe_pkg::HueSegment;
      t   = rlpe_pkg::FullScale * f / rlpe_pkg::HueSegment;
      q   = rlpe_pkg::FullScale * (rlpe_pkg::HueSegment - f) / rlpe_pkg::HueSegment;
      case (seg)
        0: begin
          r = rlpe_pkg::ChanW'(rlpe_pkg::FullScale); g = rlpe_pkg::ChanW'(t); b = '0;
        end
        1: begin
          r = rlpe_pkg::ChanW'(q); g = rlpe_pkg::ChanW'(rlpe_pkg::FullScale); b = '0;
        end
        2: begin
          r = '0; g = rlpe_pkg::ChanW'(rlpe_pkg::FullScale); b = rlpe_pkg::ChanW'(t);
        end
        3: begin
          r = '0; g = rlpe_pkg::ChanW'(q); b = rlpe_pkg::ChanW'(rlpe_pkg::FullScale);
        end
        4: begin
          r = rlpe_pkg::ChanW'(t); g = '0; b = rlpe_pkg::ChanW'(rlpe_pkg::FullScale);
        end
        default: begin
          r = rlpe_pkg::ChanW'(rlpe_pkg::FullScale); g = '0; b = rlpe_pkg::ChanW'(q);
        end
      endcase
    end else begin
      r = req.red;
      g = req.green;
      b = req.blue;
    end
    grb = {g, r, b};
    frame_pos = frame_pos + rlpe_pkg::CountW'(1);
    closes = (frame_pos >= frame_leds);
    // data slots go out MSB first
    for (int i = rlpe_pkg::ColorW - 1; i >= 0; i--) begin
      s.pulse_high   = grb[i] ? one_ticks : zero_ticks;
      s.repeat_slots = rlpe_pkg::CountW'(1);
      s.is_latch     = 1'b0;
      s.run_end      = !closes && (i == 0);
      due_slots.push_back(s);
    end
    if (closes) begin
      s.pulse_high   = '0;
      s.repeat_slots = (latch_len == '0) ? rlpe_pkg::CountW'(1) : latch_len;
      s.is_latch     = 1'b1;
      s.run_end      = 1'b1;
      due_slots.push_back(s);
      frame_pos = '0;
    end
  endfunction

  // Driver: count accepted requests, then present the next one or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        encode_led(on_bus);
      end
      if (!push || !full) begin
        if (led_backlog.size() != 0 && (quiet || $urandom_range(99) >= 14)) begin
          on_bus = led_backlog.pop_front();
          push    <= 1'b1;
          cmd_i   <= on_bus.cmd;
          red_i   <= on_bus.red;
          green_i <= on_bus.green;
          blue_i  <= on_bus.blue;
          hue_i   <= on_bus.hue;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      bad_slots++;
      if (bad_slots <= 60) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  // Monitor: compare each popped slot with the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    slot_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (due_slots.size() == 0) begin
          bad_slots++;
          if (bad_slots <= 60) begin
            $display("%0t: unexpected slot, expected none, actual pulse %0d rep %0d",
                     $time, pulse_high_o, repeat_slots_o);
          end
        end else begin
          want = due_slots.pop_front();
          check_field("pulse_high", 16'(want.pulse_high), 16'(pulse_high_o));
          check_field("repeat_slots", 16'(want.repeat_slots), 16'(repeat_slots_o));
          check_field("is_latch", 16'(want.is_latch), 16'(is_latch_o));
          check_field("run_end", 16'(want.run_end), 16'(run_end_o));
        end
      end
      pop <= quiet || ($urandom_range(99) >= 14);
    end
  end

  // Write one register while the block is idle and mirror it in the predictor
  task automatic write_reg(rlpe_pkg::cfg_idx_e idx, logic [rlpe_pkg::CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rlpe_pkg::CfgOneHigh:  one_ticks  = value;
      rlpe_pkg::CfgZeroHigh: zero_ticks = value;
      rlpe_pkg::CfgLatch:    latch_len  = value[rlpe_pkg::CountW-1:0];
      default:               frame_leds = value[rlpe_pkg::CountW-1:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic add_rgb(logic [rlpe_pkg::ChanW-1:0] r, logic [rlpe_pkg::ChanW-1:0] g,
                         logic [rlpe_pkg::ChanW-1:0] b);
    led_req_t req;
    req = '{rlpe_pkg::CmdRgb, r, g, b, rlpe_pkg::HueW'($urandom_range(65535))};
    led_backlog.push_back(req);
    sent++;
  endtask

  task automatic add_hue(logic [rlpe_pkg::HueW-1:0] h);
    led_req_t req;
    req = '{rlpe_pkg::CmdHue, rlpe_pkg::ChanW'($urandom), rlpe_pkg::ChanW'($urandom),
            rlpe_pkg::ChanW'($urandom), h};
    led_backlog.push_back(req);
    sent++;
  endtask

  // Random channel: extremes now and then, otherwise any value
  function automatic logic [rlpe_pkg::ChanW-1:0] rand_chan();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return rlpe_pkg::ChanW'($urandom);
    endcase
  endfunction

  task automatic add_random(int unsigned n);
    int unsigned seg;
    repeat (n) begin
      if ($urandom_range(1) == 0) begin
        add_rgb(rand_chan(), rand_chan(), rand_chan());
      end else if ($urandom_range(3) == 0) begin
        // land on a segment edge, possibly past the first turn of the circle
        seg = $urandom_range(11);
        add_hue(rlpe_pkg::HueW'(seg * rlpe_pkg::HueSegment
                + ($urandom_range(1) ? rlpe_pkg::HueSegment - 1 : 0)
                + rlpe_pkg::HueCircle * $urandom_range(3)));
      end else begin
        add_hue(rlpe_pkg::HueW'($urandom_range(65535)));
      end
    end
  endtask

  // Wait until every request is in and every slot has been popped
  task automatic drain();
    @(negedge clk_i);
    while (led_backlog.size() != 0 || push || due_slots.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (6) @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // colour extremes and hue segment edges under reset settings
    add_rgb(8'h00, 8'h00, 8'h00);
    add_rgb(8'hFF, 8'hFF, 8'hFF);
    add_rgb(8'hFF, 8'h00, 8'h00);
    add_rgb(8'h00, 8'hFF, 8'h00);
    add_rgb(8'h00, 8'h00, 8'hFF);
    add_rgb(8'hAA, 8'h55, 8'hA5);
    add_hue(16'd0);
    add_hue(16'd59);
    add_hue(16'd60);
    add_hue(16'd119);
    add_hue(16'd120);
    add_hue(16'd179);
    add_hue(16'd180);
    add_hue(16'd239);
    add_hue(16'd240);
    add_hue(16'd299);
    add_hue(16'd300);
    add_hue(16'd359);
    add_hue(16'd360);
    add_hue(16'hFFFF);
    drain();

    // widest ticks, longest latch, one LED per frame
    write_reg(rlpe_pkg::CfgOneHigh, 10'h3FF);
    write_reg(rlpe_pkg::CfgZeroHigh, 10'h000);
    write_reg(rlpe_pkg::CfgLatch, 10'h0FF);
    write_reg(rlpe_pkg::CfgLedCount, 10'd1);
    add_random(30);
    drain();

    // zero latch length and zero LED count, set through masked upper bits
    write_reg(rlpe_pkg::CfgOneHigh, 10'h000);
    write_reg(rlpe_pkg::CfgZeroHigh, 10'h3FF);
    write_reg(rlpe_pkg::CfgLatch, 10'h100);
    write_reg(rlpe_pkg::CfgLedCount, 10'h200);
    add_random(20);
    drain();

    // long frame, then lower the count below the current position
    write_reg(rlpe_pkg::CfgOneHigh, 10'd150);
    write_reg(rlpe_pkg::CfgZeroHigh, 10'd75);
    write_reg(rlpe_pkg::CfgLatch, 10'd1);
    write_reg(rlpe_pkg::CfgLedCount, 10'd255);
    add_random(40);
    drain();
    write_reg(rlpe_pkg::CfgLedCount, 10'd10);
    add_random(12);
    drain();

    // random settings between drained chunks
    while (sent < 280) begin
      write_reg(rlpe_pkg::CfgOneHigh, rlpe_pkg::CfgDataW'($urandom));
      write_reg(rlpe_pkg::CfgZeroHigh, rlpe_pkg::CfgDataW'($urandom));
      write_reg(rlpe_pkg::CfgLatch, rlpe_pkg::CfgDataW'($urandom));
      if ($urandom_range(3) == 0) begin
        write_reg(rlpe_pkg::CfgLedCount, rlpe_pkg::CfgDataW'($urandom));
      end else begin
        write_reg(rlpe_pkg::CfgLedCount, rlpe_pkg::CfgDataW'($urandom_range(1, 7)));
      end
      add_random($urandom_range(15, 40));
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (bad_slots == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
